### rtl/gup_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gup_pkg
// Shared types and constants for the GIF uncompressed pixel packer.
// ----------------------------------------------------------------------------
package gup_pkg;

    localparam int BLOCK_PIXELS_DEF = 126;
    localparam int PIXEL_W          = 16;
    localparam int COUNT_W          = 24;
    localparam int CODE_W           = 7;
    localparam int BYTE_W           = 8;
    localparam int CFG_ADDR_W       = 1;
    localparam int CFG_DATA_W       = 24;

    localparam int QUEUE_DEPTH      = 4;
    localparam int QUEUE_PTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [CFG_ADDR_W-1:0] REG_GRAY_MODE    = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_PIXELS = 1'b1;

    localparam logic [BYTE_W-1:0] CLEAR_CODE = 8'h80;
    localparam logic [BYTE_W-1:0] END_LEAD   = 8'h01;
    localparam logic [BYTE_W-1:0] END_CODE   = 8'h81;
    localparam logic [BYTE_W-1:0] END_TAIL   = 8'h00;

    typedef struct packed {
        logic               gray_mode;
        logic [COUNT_W-1:0] frame_pixels;
    } cfg_t;

    // one classified pixel, handed from the front to the back
    typedef struct packed {
        logic              hdr;       // sub-block length + clear code first
        logic [BYTE_W-1:0] len_byte;
        logic [CODE_W-1:0] code;
        logic              last_px;   // frame's final pixel, end code follows
    } cmd_t;

    typedef enum logic [2:0] {
        KIND_LEN,
        KIND_CLR,
        KIND_PIX,
        KIND_E1,
        KIND_E2,
        KIND_E3
    } kind_t;

endpackage

### rtl/gup_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gup_front
// Classifies each pixel: 7-bit code, sub-block header, end of frame.
// ----------------------------------------------------------------------------
module gup_front #(
    parameter int BLOCK_PIXELS = gup_pkg::BLOCK_PIXELS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  gup_pkg::cfg_t                   cfg,
    input  logic                            push,
    input  logic [gup_pkg::PIXEL_W-1:0]     pixel_value,
    output gup_pkg::cmd_t                   cmd
);
    import gup_pkg::*;

    localparam int BP_W = (BLOCK_PIXELS > 1) ? $clog2(BLOCK_PIXELS) : 1;
    localparam logic [BP_W-1:0]    BP_LAST = BP_W'(BLOCK_PIXELS - 1);
    localparam logic [COUNT_W-1:0] BLK_CAP = COUNT_W'(BLOCK_PIXELS);

    logic [BP_W-1:0]    block_position_reg, block_position_next;
    logic [COUNT_W-1:0] pixels_done_reg, pixels_done_next;
    logic [COUNT_W-1:0] left;
    logic [COUNT_W-1:0] len;

    always_comb begin
        left = cfg.frame_pixels - pixels_done_reg;
        // zero left means a full 2^24 frame remains
        if (left == '0 || left >= BLK_CAP) begin
            len = BLK_CAP;
        end else begin
            len = left;
        end
        cmd.hdr      = (block_position_reg == '0);
        cmd.len_byte = BYTE_W'(len) + BYTE_W'(1);
        cmd.last_px  = (left == COUNT_W'(1));
        if (cfg.gray_mode) begin
            cmd.code = pixel_value[7:1];
        end else begin
            cmd.code = {pixel_value[15:14], pixel_value[10:8], pixel_value[4:3]};
        end
    end

    always_comb begin
        block_position_next = block_position_reg;
        pixels_done_next    = pixels_done_reg;
        if (push) begin
            if (cmd.last_px) begin
                block_position_next = '0;
                pixels_done_next    = '0;
            end else begin
                pixels_done_next = pixels_done_reg + COUNT_W'(1);
                if (block_position_reg == BP_LAST) begin
                    block_position_next = '0;
                end else begin
                    block_position_next = block_position_reg + BP_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_position_reg <= '0;
            pixels_done_reg    <= '0;
        end else begin
            block_position_reg <= block_position_next;
            pixels_done_reg    <= pixels_done_next;
        end
    end

endmodule

### rtl/gup_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gup_queue
// Short FIFO of classified pixels between front and back.
// ----------------------------------------------------------------------------
module gup_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  gup_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output gup_pkg::cmd_t head,
    output logic          head_valid
);
    import gup_pkg::*;

    cmd_t                 entries_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_PTR_W:0]   count_reg, count_next;

    assign full       = (count_reg == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entries_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + (QUEUE_PTR_W+1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (QUEUE_PTR_W+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

### rtl/gup_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gup_back
// Expands each classified pixel into its byte sequence, one byte per beat.
// ----------------------------------------------------------------------------
module gup_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  gup_pkg::cmd_t               head,
    input  logic                        head_valid,
    output logic                        pop,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [gup_pkg::BYTE_W-1:0]  out_byte,
    output logic                        out_last,
    output logic                        out_done
);
    import gup_pkg::*;

    logic              cur_valid_reg, cur_valid_next;
    cmd_t              cur_cmd_reg, cur_cmd_next;
    kind_t             kind_reg, kind_next;
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic              out_last_reg, out_last_next;
    logic              out_done_reg, out_done_next;

    cmd_t              src;
    kind_t             src_kind;
    kind_t             step_next;
    logic [BYTE_W-1:0] step_byte;
    logic              step_end;
    logic              load;

    // with nothing in flight, the queue head is worked on directly
    always_comb begin
        src      = cur_valid_reg ? cur_cmd_reg : head;
        src_kind = cur_valid_reg ? kind_reg : (head.hdr ? KIND_LEN : KIND_PIX);
        load     = (cur_valid_reg || head_valid) && (!out_valid_reg || out_ready);
        pop      = load && !cur_valid_reg;
    end

    always_comb begin
        step_byte = END_TAIL;
        step_end  = 1'b1;
        step_next = KIND_PIX;
        unique case (src_kind)
            KIND_LEN: begin
                step_byte = src.len_byte;
                step_end  = 1'b0;
                step_next = KIND_CLR;
            end
            KIND_CLR: begin
                step_byte = CLEAR_CODE;
                step_end  = 1'b0;
                step_next = KIND_PIX;
            end
            KIND_PIX: begin
                step_byte = {1'b0, src.code};
                step_end  = !src.last_px;
                step_next = KIND_E1;
            end
            KIND_E1: begin
                step_byte = END_LEAD;
                step_end  = 1'b0;
                step_next = KIND_E2;
            end
            KIND_E2: begin
                step_byte = END_CODE;
                step_end  = 1'b0;
                step_next = KIND_E3;
            end
            KIND_E3: begin
                step_byte = END_TAIL;
                step_end  = 1'b1;
                step_next = KIND_PIX;
            end
            default: begin
                step_byte = END_TAIL;
                step_end  = 1'b1;
                step_next = KIND_PIX;
            end
        endcase
    end

    always_comb begin
        cur_valid_next = cur_valid_reg;
        cur_cmd_next   = cur_cmd_reg;
        kind_next      = kind_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_done_next  = out_done_reg;
        if (load) begin
            cur_valid_next = !step_end;
            cur_cmd_next   = src;
            kind_next      = step_next;
            out_valid_next = 1'b1;
            out_byte_next  = step_byte;
            out_last_next  = step_end;
            out_done_next  = (src_kind == KIND_E3);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            kind_reg      <= KIND_PIX;
            out_valid_reg <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            kind_reg      <= kind_next;
            out_valid_reg <= out_valid_next;
        end
        cur_cmd_reg  <= cur_cmd_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        out_done_reg <= out_done_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;
    assign out_done  = out_done_reg;

endmodule

### rtl/gif_uncompressed_pixel_packer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gif_uncompressed_pixel_packer_top
// Pixel stream in, GIF image-data bytes (uncompressed 7-bit codes) out.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one pixel per beat (grayscale in the low byte, or RGB565).
//   m_ channel: one image-data byte per beat; m_tlast marks the final byte
//   caused by a pixel, m_tuser marks the final byte of the frame's end code.
//   cfg port: write gray_mode (index 0) and frame_pixels (index 1) while idle.
// Timing:
//   A pixel's first byte is presented after its beat passes through the queue and the output register.
//   The output side moves one byte per cycle while m_tready is high; a plain
//   pixel gives one byte, a pixel that opens a sub-block three, and the
//   frame's final pixel three more for the end code. A four-entry queue lets
//   the input keep going while the output works through those extra bytes.
// Reset:
//   Clears the counters, the queue and the output valid flag; gray_mode goes
//   to 0 and frame_pixels to 1.
// Stall:
//   With m_tready low the output byte holds; the queue fills and s_tready
//   drops once all four entries are taken.
// ----------------------------------------------------------------------------
module gif_uncompressed_pixel_packer_top #(
    parameter int BLOCK_PIXELS = gup_pkg::BLOCK_PIXELS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration writes
    input  logic                              cfg_wr_en,
    input  logic [gup_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [gup_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    // pixel input
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [gup_pkg::PIXEL_W-1:0]       s_tdata,   // [15:0] pixel_value
    // byte output
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [gup_pkg::BYTE_W-1:0]        m_tdata,   // [7:0] out_byte
    output logic                              m_tlast,   // last_of_run
    output logic                              m_tuser    // [0] frame_done
);
    import gup_pkg::*;

    cfg_t cfg_reg;
    cmd_t front_cmd;
    cmd_t head;
    logic head_valid;
    logic queue_full;
    logic push;
    logic pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gray_mode    <= 1'b0;
            cfg_reg.frame_pixels <= COUNT_W'(1);
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_GRAY_MODE:    cfg_reg.gray_mode    <= cfg_wr_data[0];
                REG_FRAME_PIXELS: cfg_reg.frame_pixels <= cfg_wr_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign s_tready = !queue_full;
    assign push     = s_tvalid && s_tready;

    gup_front #(
        .BLOCK_PIXELS (BLOCK_PIXELS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .push        (push),
        .pixel_value (s_tdata),
        .cmd         (front_cmd)
    );

    gup_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_cmd   (front_cmd),
        .full       (queue_full),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid)
    );

    gup_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_byte   (m_tdata),
        .out_last   (m_tlast),
        .out_done   (m_tuser)
    );

    // end of frame closes the run on the end code's zero byte
    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast && (m_tdata == END_TAIL))
        else $error("frame_done without last_of_run on a zero byte");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    // the queue never pops when empty
    a_pop_has_data: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("queue popped while empty");

endmodule
